// ----- hw/rtl/dpu_pkg.sv -----
// dpu_pkg: shared constants, register codes, sequencer states and control structs
// for the dual-PRF Doppler unfolding core; depends on nothing
`default_nettype none

package dpu_pkg;

  // default parameter values
  localparam int DEF_MAX_CPI_LOG2 = 10;
  localparam int DEF_PRF_WIDTH    = 20;
  localparam int DEF_ACC_WIDTH    = 44;

  // fixed field widths
  localparam int BIN_W      = 10;
  localparam int CPI_W      = 4;
  localparam int HW_W       = 24;
  localparam int VEL_W      = 40;
  localparam int LO_W       = 15;  // low slice of the magnitude in the velocity scaling
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // register reset values
  localparam int RST_PRF_FIRST  = 10000;
  localparam int RST_PRF_SECOND = 12500;
  localparam int RST_CPI_LOG2   = 5;
  localparam int RST_HALF_WL    = 251658;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRF_FIRST  = 3'd0,
    REG_PRF_SECOND = 3'd1,
    REG_CPI_LOG2   = 3'd2,
    REG_HALF_WL    = 3'd3,
    REG_DIRECTION  = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_FD1,
    ST_MUL_FD2,
    ST_LOAD_FD2,
    ST_UNFOLD,
    ST_SC_HI,
    ST_SC_LO,
    ST_SC_SUM,
    ST_SC_SHIFT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    MUL_FD1,
    MUL_FD2,
    MUL_HI,
    MUL_LO
  } mul_src_t;

  typedef struct packed {
    logic     idle;
    logic     start;
    mul_src_t mul_src;
    logic     load_fd1;
    logic     load_fd2;
    logic     unfold;
    logic     step;
    logic     load_t;
    logic     add_lo;
    logic     round;
    logic     done;
  } ctrl_t;

  typedef struct packed {
    logic over;
    logic converged;
  } stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dpu_ifs.sv -----
// dpu_ifs: valid/ready channel interfaces for input, result and register-write words
// depends on dpu_pkg
`default_nettype none

interface dpu_in_if;
  logic                        valid;
  logic                        ready;
  logic [dpu_pkg::BIN_W-1:0]   bin_first;
  logic [dpu_pkg::BIN_W-1:0]   bin_second;
  modport source (output valid, bin_first, bin_second, input ready);
  modport sink   (input valid, bin_first, bin_second, output ready);
endinterface

interface dpu_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dpu_pkg::VEL_W-1:0]   velocity;
  logic                               status;
  modport source (output valid, velocity, status, input ready);
  modport sink   (input valid, velocity, status, output ready);
endinterface

interface dpu_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dpu_pkg::CFG_IDX_W-1:0]    index;
  logic [dpu_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/dpu_cfg_regs.sv -----
// dpu_cfg_regs: configuration register file written through the cfg channel
// depends on dpu_pkg and dpu_ifs
`default_nettype none

module dpu_cfg_regs #(
  parameter int PRF_WIDTH = dpu_pkg::DEF_PRF_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  dpu_cfg_if.sink                     cfg_ch,
  output logic [PRF_WIDTH-1:0]        prf_first,
  output logic [PRF_WIDTH-1:0]        prf_second,
  output logic [dpu_pkg::CPI_W-1:0]   cpi_log2,
  output logic [dpu_pkg::HW_W-1:0]    half_wl,
  output logic                        dir
);

  logic [PRF_WIDTH-1:0]      prf_first_r;
  logic [PRF_WIDTH-1:0]      prf_second_r;
  logic [dpu_pkg::CPI_W-1:0] cpi_log2_r;
  logic [dpu_pkg::HW_W-1:0]  half_wl_r;
  logic                      dir_r;

  // writes must only be issued while idle, which the block itself leaves to the user; always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prf_first_r  <= PRF_WIDTH'(dpu_pkg::RST_PRF_FIRST);
      prf_second_r <= PRF_WIDTH'(dpu_pkg::RST_PRF_SECOND);
      cpi_log2_r   <= dpu_pkg::CPI_W'(dpu_pkg::RST_CPI_LOG2);
      half_wl_r    <= dpu_pkg::HW_W'(dpu_pkg::RST_HALF_WL);
      dir_r        <= 1'b0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (dpu_pkg::cfg_reg_t'(cfg_ch.index))
        dpu_pkg::REG_PRF_FIRST:  prf_first_r  <= PRF_WIDTH'(cfg_ch.data);
        dpu_pkg::REG_PRF_SECOND: prf_second_r <= PRF_WIDTH'(cfg_ch.data);
        dpu_pkg::REG_CPI_LOG2:   cpi_log2_r   <= cfg_ch.data[dpu_pkg::CPI_W-1:0];
        dpu_pkg::REG_HALF_WL:    half_wl_r    <= cfg_ch.data[dpu_pkg::HW_W-1:0];
        dpu_pkg::REG_DIRECTION:  dir_r        <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  assign prf_first  = prf_first_r;
  assign prf_second = prf_second_r;
  assign cpi_log2   = cpi_log2_r;
  assign half_wl    = half_wl_r;
  assign dir        = dir_r;

endmodule

`default_nettype wire

// ----- hw/rtl/dpu_mul.sv -----
// dpu_mul: shared unsigned multiplier with a registered product
// depends on nothing
`default_nettype none

module dpu_mul #(
  parameter int A_W = 29,
  parameter int B_W = 24
) (
  input  logic               clk,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] prod
);

  logic [A_W+B_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= {{B_W{1'b0}}, a} * {{A_W{1'b0}}, b};
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ----- hw/rtl/dpu_datapath.sv -----
// dpu_datapath: doppler accumulators, shared step adder, limit compares and
// velocity scaling around the shared multiplier; depends on dpu_pkg and dpu_mul
`default_nettype none

module dpu_datapath #(
  parameter int MAX_CPI_LOG2 = dpu_pkg::DEF_MAX_CPI_LOG2,
  parameter int PRF_WIDTH    = dpu_pkg::DEF_PRF_WIDTH,
  parameter int ACC_WIDTH    = dpu_pkg::DEF_ACC_WIDTH
) (
  input  logic                               clk,
  input  dpu_pkg::ctrl_t                     ctrl,
  input  logic [PRF_WIDTH-1:0]               prf_first,
  input  logic [PRF_WIDTH-1:0]               prf_second,
  input  logic [dpu_pkg::CPI_W-1:0]          cpi_log2,
  input  logic [dpu_pkg::HW_W-1:0]           half_wl,
  input  logic                               dir,
  input  logic [dpu_pkg::BIN_W-1:0]          bin_first,
  input  logic [dpu_pkg::BIN_W-1:0]          bin_second,
  output dpu_pkg::stat_t                     stat,
  output logic signed [dpu_pkg::VEL_W-1:0]   velocity,
  output logic                               status
);

  localparam int C_W    = $clog2(MAX_CPI_LOG2 + 1);
  localparam int STEP_W = PRF_WIDTH + MAX_CPI_LOG2;
  localparam int LIM_W  = PRF_WIDTH + 2 * MAX_CPI_LOG2;
  localparam int CMP_W  = (ACC_WIDTH + 2 > LIM_W + 1) ? ACC_WIDTH + 2 : LIM_W + 1;
  localparam int HI_W   = ACC_WIDTH - dpu_pkg::LO_W;
  localparam int MA_W   = (PRF_WIDTH > HI_W) ? PRF_WIDTH : HI_W;
  localparam int MB_W   = dpu_pkg::HW_W;
  localparam int P_W    = MA_W + MB_W;
  localparam int T_W    = P_W + 1;
  localparam int MX_W   = (T_W > dpu_pkg::VEL_W) ? T_W : dpu_pkg::VEL_W;
  localparam int VW     = dpu_pkg::VEL_W;

  logic [dpu_pkg::BIN_W-1:0] bin1_r, bin2_r;
  logic [C_W-1:0]            c_r;
  logic [STEP_W-1:0]         step1_r, step2_r;
  logic [LIM_W-1:0]          lim1_r, lim2_r;
  logic                      over_r;
  logic                      stepped_r;
  logic signed [ACC_WIDTH-1:0] fd1_r, fd2_r;
  logic [ACC_WIDTH-1:0]      mag_r;
  logic                      neg_r;
  logic [T_W-1:0]            t_r;
  logic [T_W-1:0]            m_r;

  logic [C_W-1:0]            c_sat;
  logic [MA_W-1:0]           mul_a;
  logic [MB_W-1:0]           mul_b;
  logic [P_W-1:0]            prod;

  logic [ACC_WIDTH:0]        diff;
  logic [ACC_WIDTH:0]        abs_d;
  logic                      converged;
  logic                      sel1;
  logic [ACC_WIDTH-1:0]      acc_in;
  logic [ACC_WIDTH-1:0]      addend;
  logic [ACC_WIDTH-1:0]      sum;
  logic signed [CMP_W-1:0]   q1, q2, l1, l2;
  logic                      over_now;

  logic [MX_W-1:0]           m_ext;
  logic [VW-1:0]             mag_sat;

  // pulse count exponent clamps at the maximum
  assign c_sat = (cpi_log2 > dpu_pkg::CPI_W'(MAX_CPI_LOG2)) ? C_W'(MAX_CPI_LOG2)
                                                           : C_W'(cpi_log2);

  // shared multiplier operand select
  always_comb begin
    mul_b = half_wl;
    case (ctrl.mul_src)
      dpu_pkg::MUL_FD1: begin
        mul_a = MA_W'(prf_first);
        mul_b = MB_W'(bin1_r);
      end
      dpu_pkg::MUL_FD2: begin
        mul_a = MA_W'(prf_second);
        mul_b = MB_W'(bin2_r);
      end
      dpu_pkg::MUL_HI: mul_a = MA_W'(mag_r >> dpu_pkg::LO_W);
      dpu_pkg::MUL_LO: mul_a = MA_W'(mag_r[dpu_pkg::LO_W-1:0]);
      default:         mul_a = '0;
    endcase
  end

  dpu_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // distance between the two values and the step choice
  always_comb begin
    diff      = {fd1_r[ACC_WIDTH-1], fd1_r} - {fd2_r[ACC_WIDTH-1], fd2_r};
    abs_d     = diff[ACC_WIDTH] ? (~diff + 1'b1) : diff;
    converged = abs_d <= (ACC_WIDTH + 1)'(prf_first);
    sel1      = dir ? (!diff[ACC_WIDTH] && (diff != '0)) : diff[ACC_WIDTH];
    acc_in    = sel1 ? fd1_r : fd2_r;
    addend    = sel1 ? ACC_WIDTH'(step1_r) : ACC_WIDTH'(step2_r);
    sum       = dir ? (acc_in - addend) : (acc_in + addend);
  end

  // limit test on the values left by the previous step
  always_comb begin
    q1 = CMP_W'(fd1_r) <<< 2;
    q2 = CMP_W'(fd2_r) <<< 2;
    l1 = $signed(CMP_W'(lim1_r));
    l2 = $signed(CMP_W'(lim2_r));
    if (dir) begin
      over_now = stepped_r && ((q1 < -l1) || (q2 < -l2));
    end else begin
      over_now = stepped_r && ((q1 > l1) || (q2 > l2));
    end
  end

  assign stat.over      = over_r | over_now;
  assign stat.converged = converged;

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      bin1_r  <= bin_first;
      bin2_r  <= bin_second;
      c_r     <= c_sat;
      step1_r <= STEP_W'(prf_first) << c_sat;
      step2_r <= STEP_W'(prf_second) << c_sat;
      lim1_r  <= LIM_W'(prf_first) << {c_sat, 1'b0};
      lim2_r  <= LIM_W'(prf_second) << {c_sat, 1'b0};
      over_r  <= (prf_first == '0) || (prf_second == '0);
    end
    if (ctrl.load_fd1) begin
      fd1_r     <= ACC_WIDTH'(prod);
      stepped_r <= 1'b0;
    end
    if (ctrl.load_fd2) begin
      fd2_r <= ACC_WIDTH'(prod);
    end
    if (ctrl.unfold) begin
      over_r <= stat.over;
      mag_r  <= fd1_r[ACC_WIDTH-1] ? ACC_WIDTH'(-fd1_r) : ACC_WIDTH'(fd1_r);
      neg_r  <= fd1_r[ACC_WIDTH-1];
      if (ctrl.step) begin
        stepped_r <= 1'b1;
        if (sel1) begin
          fd1_r <= sum;
        end else begin
          fd2_r <= sum;
        end
      end
    end
    if (ctrl.load_t) begin
      t_r <= T_W'(prod);
    end
    if (ctrl.add_lo) begin
      t_r <= t_r + T_W'(prod >> dpu_pkg::LO_W);
    end
    if (ctrl.round) begin
      m_r <= ((t_r >> c_r) + T_W'(1)) >> 1;
    end
  end

  // saturate and apply the sign; velocity is forced to zero when over the limit
  always_comb begin
    m_ext = MX_W'(m_r);
    if (m_ext > MX_W'({1'b0, {(VW-1){1'b1}}})) begin
      mag_sat = neg_r ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    end else begin
      mag_sat = VW'(m_ext);
    end
    if (over_r) begin
      velocity = '0;
    end else begin
      velocity = neg_r ? $signed(~mag_sat + 1'b1) : $signed(mag_sat);
    end
    status = over_r;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dpu_seq.sv -----
// dpu_seq: sequencer stepping one item through products, unfolding and, unless over the limit, scaling
// depends on dpu_pkg
`default_nettype none

module dpu_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            out_free,
  input  dpu_pkg::stat_t  stat,
  output dpu_pkg::ctrl_t  ctrl
);

  dpu_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dpu_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dpu_pkg::ST_IDLE:     if (in_valid) state_nxt = dpu_pkg::ST_MUL_FD1;
      dpu_pkg::ST_MUL_FD1:  state_nxt = dpu_pkg::ST_MUL_FD2;
      dpu_pkg::ST_MUL_FD2:  state_nxt = dpu_pkg::ST_LOAD_FD2;
      dpu_pkg::ST_LOAD_FD2: state_nxt = dpu_pkg::ST_UNFOLD;
      dpu_pkg::ST_UNFOLD: begin
        if (stat.over) begin
          state_nxt = dpu_pkg::ST_DONE;
        end else if (stat.converged) begin
          state_nxt = dpu_pkg::ST_SC_HI;
        end
      end
      dpu_pkg::ST_SC_HI:    state_nxt = dpu_pkg::ST_SC_LO;
      dpu_pkg::ST_SC_LO:    state_nxt = dpu_pkg::ST_SC_SUM;
      dpu_pkg::ST_SC_SUM:   state_nxt = dpu_pkg::ST_SC_SHIFT;
      dpu_pkg::ST_SC_SHIFT: state_nxt = dpu_pkg::ST_DONE;
      dpu_pkg::ST_DONE:     if (out_free) state_nxt = dpu_pkg::ST_IDLE;
      default:              state_nxt = dpu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl         = '0;
    ctrl.mul_src = dpu_pkg::MUL_FD1;
    case (state_r)
      dpu_pkg::ST_IDLE: begin
        ctrl.idle  = 1'b1;
        ctrl.start = in_valid;
      end
      dpu_pkg::ST_MUL_FD1: ctrl.mul_src = dpu_pkg::MUL_FD1;
      dpu_pkg::ST_MUL_FD2: begin
        ctrl.mul_src  = dpu_pkg::MUL_FD2;
        ctrl.load_fd1 = 1'b1;
      end
      dpu_pkg::ST_LOAD_FD2: ctrl.load_fd2 = 1'b1;
      dpu_pkg::ST_UNFOLD: begin
        ctrl.unfold = 1'b1;
        ctrl.step   = !stat.over && !stat.converged;
      end
      dpu_pkg::ST_SC_HI: ctrl.mul_src = dpu_pkg::MUL_HI;
      dpu_pkg::ST_SC_LO: begin
        ctrl.mul_src = dpu_pkg::MUL_LO;
        ctrl.load_t  = 1'b1;
      end
      dpu_pkg::ST_SC_SUM:   ctrl.add_lo = 1'b1;
      dpu_pkg::ST_SC_SHIFT: ctrl.round  = 1'b1;
      dpu_pkg::ST_DONE:     ctrl.done   = out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dual_prf_doppler_unfold_core.sv -----
// one item in flight: the next input word is taken only after the result word has been
// written to the output register, so later while an earlier result word waits at the output
// unfolding runs on the shared step adder, one step per cycle, until the two values
// converge or pass the limit; over the limit the scaling steps are skipped
// reset: synchronous, active low; registers go to defaults, sequencer and output idle
`default_nettype none

module dual_prf_doppler_unfold_core #(
  parameter int MAX_CPI_LOG2 = dpu_pkg::DEF_MAX_CPI_LOG2,
  parameter int PRF_WIDTH    = dpu_pkg::DEF_PRF_WIDTH,
  parameter int ACC_WIDTH    = dpu_pkg::DEF_ACC_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  dpu_in_if.sink      in_ch,
  dpu_out_if.source   out_ch,
  dpu_cfg_if.sink     cfg_ch
);

  // configuration register outputs
  logic [PRF_WIDTH-1:0]        prf_first;
  logic [PRF_WIDTH-1:0]        prf_second;
  logic [dpu_pkg::CPI_W-1:0]   cpi_log2;
  logic [dpu_pkg::HW_W-1:0]    half_wl;
  logic                        dir;

  // sequencer <-> datapath
  dpu_pkg::ctrl_t              ctrl;
  dpu_pkg::stat_t              stat;
  logic                        out_free;

  // result from the datapath, valid when ctrl.done
  logic signed [dpu_pkg::VEL_W-1:0] dp_velocity;
  logic                             dp_status;

  // output word register, parts the result side from the engine
  logic                             out_valid_r;
  logic signed [dpu_pkg::VEL_W-1:0] velocity_r;
  logic                             status_r;

  dpu_cfg_regs #(
    .PRF_WIDTH (PRF_WIDTH)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .prf_first  (prf_first),
    .prf_second (prf_second),
    .cpi_log2   (cpi_log2),
    .half_wl    (half_wl),
    .dir        (dir)
  );

  // output slot can take a word when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;

  dpu_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  dpu_datapath #(
    .MAX_CPI_LOG2 (MAX_CPI_LOG2),
    .PRF_WIDTH    (PRF_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_dp (
    .clk        (clk),
    .ctrl       (ctrl),
    .prf_first  (prf_first),
    .prf_second (prf_second),
    .cpi_log2   (cpi_log2),
    .half_wl    (half_wl),
    .dir        (dir),
    .bin_first  (in_ch.bin_first),
    .bin_second (in_ch.bin_second),
    .stat       (stat),
    .velocity   (dp_velocity),
    .status     (dp_status)
  );

  // input word taken only while the sequencer sits idle
  assign in_ch.ready = ctrl.idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload loads with the result, no reset needed
  always_ff @(posedge clk) begin
    if (ctrl.done) begin
      velocity_r <= dp_velocity;
      status_r   <= dp_status;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.velocity = velocity_r;
  assign out_ch.status   = status_r;

`ifndef SYNTHESIS
  // over-limit words always carry zero velocity
  a_over_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status) |-> (out_ch.velocity == '0))
    else $error("over-limit word with nonzero velocity");

  // an accepted word keeps the engine busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after accepting a word");

  // a result never overwrites a word still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.done |-> (!out_valid_r || out_ch.ready))
    else $error("result written over a pending output word");
`endif

endmodule

`default_nettype wire
